FILE: rtl/sws_pkg.sv
// Package for the signed word sorter: shared widths, request codes and the
// control struct that goes from the sorter core to its cell chain.
// Depends on nothing.
package sws_pkg;

	localparam int DATA_W        = 32;
	localparam int DEFAULT_DEPTH = 256;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		logic ins;
		logic pop;
	} chain_ctrl_t;

endpackage

FILE: rtl/sws_if.sv
// Handshake interfaces of the signed word sorter: request and result channels.
// Depends on sws_pkg.
interface sws_req_if;
	logic               valid;
	logic               ready;
	logic               action;
	sws_pkg::word_t     sample;

	modport source (output valid, output action, output sample, input ready);
	modport sink   (input valid, input action, input sample, output ready);
endinterface

interface sws_res_if;
	logic               valid;
	logic               ready;
	sws_pkg::word_t     sorted_value;
	logic               final_word;
	logic               empty_res;
	logic               overflowed;

	modport source (output valid, output sorted_value, output final_word,
		output empty_res, output overflowed, input ready);
	modport sink   (input valid, input sorted_value, input final_word,
		input empty_res, input overflowed, output ready);
endinterface

FILE: rtl/signed_word_sorter_core.sv
// Signed word sorter: load requests insert each word into a chain of BATCH_DEPTH
// cells kept in ascending order, so the batch is sorted as it arrives; each read
// request pops the smallest word. Each word stored or popped takes one compare in
// each cell and a one-step shift of the chain; a result waits in an output
// register, and the next request is taken once that result is read, at the
// earliest in the same cycle. A read after the last word
// reports empty and rearms the block. Loads past BATCH_DEPTH are dropped and set
// the sticky overflow flag; loads between the first read and the empty report
// are ignored. Depends on sws_pkg, sws_if and sws_chain.
module signed_word_sorter_core #(
	parameter int BATCH_DEPTH = sws_pkg::DEFAULT_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	sws_req_if.sink      req,
	sws_res_if.source    res
);
	import sws_pkg::*;

	localparam int CNT_W = $clog2(BATCH_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(BATCH_DEPTH);

	logic [CNT_W-1:0] count_q;
	logic             draining_q;
	logic             ovf_q;
	logic             res_valid_q;
	word_t            res_value_q;
	logic             res_final_q;
	logic             res_empty_q;
	logic             res_ovf_q;

	chain_ctrl_t ctrl;
	word_t       head;
	logic        take;
	logic        is_load;
	logic        is_read;

	assign req.ready = !res_valid_q || res.ready;
	assign take      = req.valid && req.ready;
	assign is_load   = take && (req.action == ACT_LOAD);
	assign is_read   = take && (req.action == ACT_READ);

	always_comb begin
		ctrl.ins = is_load && !draining_q && (count_q != FULL);
		ctrl.pop = is_read && (count_q != '0);
	end

	sws_chain #(
		.DEPTH (BATCH_DEPTH),
		.CNT_W (CNT_W)
	) u_chain (
		.clk     (clk),
		.ctrl    (ctrl),
		.new_val (req.sample),
		.count   (count_q),
		.head    (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			draining_q  <= 1'b0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (is_read) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			if (is_load && !draining_q) begin
				if (count_q == FULL) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (is_read) begin
				if (count_q == '0) begin
					draining_q <= 1'b0;
					ovf_q      <= 1'b0;
				end else begin
					draining_q <= 1'b1;
					count_q    <= count_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_read) begin
			res_ovf_q <= ovf_q;
			if (count_q == '0) begin
				res_value_q <= '0;
				res_final_q <= 1'b0;
				res_empty_q <= 1'b1;
			end else begin
				res_value_q <= head;
				res_final_q <= (count_q == CNT_W'(1));
				res_empty_q <= 1'b0;
			end
		end
	end

	assign res.valid        = res_valid_q;
	assign res.sorted_value = res_value_q;
	assign res.final_word   = res_final_q;
	assign res.empty_res    = res_empty_q;
	assign res.overflowed   = res_ovf_q;
endmodule

FILE: rtl/sws_cell.sv
// One cell of the sorting chain: holds one word; on insert it takes its left
// neighbour's word (shift right) or the new word, and on pop it shifts left.
// Depends on sws_pkg.
module sws_cell (
	input  logic                 clk,
	input  sws_pkg::chain_ctrl_t ctrl,
	input  sws_pkg::word_t       new_val,
	input  sws_pkg::word_t       left_val,
	input  logic                 left_gt,
	input  sws_pkg::word_t       right_val,
	input  logic                 occ,
	output sws_pkg::word_t       val,
	output logic                 gt
);
	import sws_pkg::*;

	word_t val_q;

	// empty cells count as larger than any word
	assign gt  = !occ || (val_q > new_val);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			val_q <= right_val;
		end else if (ctrl.ins) begin
			if (left_gt) begin
				val_q <= left_val;
			end else if (gt) begin
				val_q <= new_val;
			end
		end
	end
endmodule

FILE: rtl/sws_chain.sv
// Row of sorting cells kept in ascending order; head of the row is the minimum.
// Depends on sws_pkg and sws_cell.
module sws_chain #(
	parameter int DEPTH = sws_pkg::DEFAULT_DEPTH,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  sws_pkg::chain_ctrl_t ctrl,
	input  sws_pkg::word_t       new_val,
	input  logic [CNT_W-1:0]     count,
	output sws_pkg::word_t       head
);
	import sws_pkg::*;

	word_t vals [DEPTH];
	logic  gts  [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		word_t left_v;
		word_t right_v;
		logic  left_g;

		if (i == 0) begin : g_first
			assign left_v = new_val;
			assign left_g = 1'b0;
		end else begin : g_mid
			assign left_v = vals[i-1];
			assign left_g = gts[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_v = vals[i];
		end else begin : g_inner
			assign right_v = vals[i+1];
		end

		sws_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.new_val   (new_val),
			.left_val  (left_v),
			.left_gt   (left_g),
			.right_val (right_v),
			.occ       (IDX < count),
			.val       (vals[i]),
			.gt        (gts[i])
		);
	end

	assign head = vals[0];
endmodule
